FILE: sv/tpd_pkg.sv
// Shared types and constants of the path point decimator.
`default_nettype none
package tpd_pkg;

   localparam int unsigned REC_BYTES = 25;
   localparam int unsigned REC_W     = 8 * REC_BYTES;
   localparam int unsigned FILL_W    = $clog2(REC_BYTES);
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_PATH_TYPE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DIST  = CSR_IDX_W'(1);

   localparam logic [7:0]  PATH_TYPE_RESET = 8'd1;
   localparam logic [63:0] MIN_DIST_RESET  = 64'd250000;

   // Record layout, first byte on the wire in the top bits.
   typedef struct packed {
      logic        [31:0] t_rel;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [15:0] heading_raw;
      logic signed [15:0] speed_raw;
      logic signed [15:0] accel_raw;
      logic signed [15:0] curve_raw;
      logic        [7:0]  point_mode;
   } record_type;

   typedef struct packed {
      logic       first;
      record_type rec;
   } entry_type;

   typedef enum logic [2:0] {
      F_TYPE,
      F_LEN1,
      F_LEN2,
      F_LEN3,
      F_LEN4,
      F_PAYLOAD
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_DIFF,
      B_SQR,
      B_SUM,
      B_DEC
   } back_state_type;

endpackage
`default_nettype wire

FILE: sv/tpd_front.sv
// Frame parser: walks type, length and payload, gathers point records.
`default_nettype none
module tpd_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              byte_accept,
   input  wire logic [7:0]        rx_byte,
   input  wire logic [7:0]        path_msg_type,
   output logic                   push,
   output tpd_pkg::entry_type     push_entry
);
   import tpd_pkg::*;

   localparam logic [FILL_W-1:0] LAST_FILL = FILL_W'(REC_BYTES - 1);

   front_state_type   state_ff, state_in;
   logic [7:0]        kind_ff, kind_in;
   logic [31:0]       len_ff, len_in;
   logic [31:0]       remain_ff, remain_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [REC_W-1:0]  rec_ff, rec_in;
   logic              done_ff, done_in;
   logic [31:0]       len_next;

   assign len_next = {len_ff[23:0], rx_byte};

   always_comb begin
      state_in = state_ff;
      if (byte_accept) begin
         unique case (state_ff)
            F_TYPE:    state_in = F_LEN1;
            F_LEN1:    state_in = F_LEN2;
            F_LEN2:    state_in = F_LEN3;
            F_LEN3:    state_in = F_LEN4;
            F_LEN4:    state_in = (len_next == 32'd0) ? F_TYPE : F_PAYLOAD;
            F_PAYLOAD: state_in = (remain_ff == 32'd1) ? F_TYPE : F_PAYLOAD;
            default:   state_in = F_TYPE;
         endcase
      end
   end

   always_comb begin
      kind_in   = kind_ff;
      len_in    = len_ff;
      remain_in = remain_ff;
      fill_in   = fill_ff;
      rec_in    = rec_ff;
      done_in   = done_ff;
      push      = 1'b0;
      if (byte_accept) begin
         unique case (state_ff)
            F_TYPE: begin
               kind_in = rx_byte;
               len_in  = 32'd0;
               fill_in = '0;
               done_in = 1'b0;
            end
            F_LEN1, F_LEN2, F_LEN3: begin
               len_in = len_next;
            end
            F_LEN4: begin
               len_in    = len_next;
               remain_in = len_next;
            end
            F_PAYLOAD: begin
               remain_in = remain_ff - 32'd1;
               if (kind_ff == path_msg_type) begin
                  rec_in = {rec_ff[REC_W-9:0], rx_byte};
                  if (fill_ff == LAST_FILL) begin
                     fill_in = '0;
                     done_in = 1'b1;
                     push    = 1'b1;
                  end else begin
                     fill_in = fill_ff + FILL_W'(1);
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign push_entry.first = ~done_ff;
   assign push_entry.rec   = record_type'(rec_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= F_TYPE;
         kind_ff   <= 8'd0;
         len_ff    <= 32'd0;
         remain_ff <= 32'd0;
         fill_ff   <= '0;
         done_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         kind_ff   <= kind_in;
         len_ff    <= len_in;
         remain_ff <= remain_in;
         fill_ff   <= fill_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

endmodule
`default_nettype wire

FILE: sv/tpd_queue.sv
// Short record queue between the frame parser and the distance unit.
`default_nettype none
module tpd_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire tpd_pkg::entry_type push_entry,
   input  wire logic               pop,
   output tpd_pkg::entry_type      head,
   output logic                    not_empty,
   output logic                    full
);
   import tpd_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

   entry_type         slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign head      = slot_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == FULL_CNT);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

FILE: sv/tpd_back.sv
// Distance unit: squared distance to the last kept point, keep decision, result register.
`default_nettype none
module tpd_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire tpd_pkg::entry_type head,
   input  wire logic               head_valid,
   input  wire logic [63:0]        min_dist_sq,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output tpd_pkg::entry_type      rsp_entry
);
   import tpd_pkg::*;

   back_state_type state_ff, state_in;
   entry_type      ent_ff;
   logic [31:0]    last_ff [3];
   logic [31:0]    mag_ff [3];
   logic [63:0]    sq_ff [3];
   logic [65:0]    sum_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           keep;
   logic [31:0]    pos [3];
   logic [32:0]    diff [3];
   logic [31:0]    mag_in [3];

   assign pos[0] = ent_ff.rec.pos_x;
   assign pos[1] = ent_ff.rec.pos_y;
   assign pos[2] = ent_ff.rec.pos_z;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         diff[k]   = {pos[k][31], pos[k]} - {last_ff[k][31], last_ff[k]};
         mag_in[k] = diff[k][32] ? 32'(-diff[k]) : diff[k][31:0];
      end
   end

   assign keep = ent_ff.first || (sum_ff > {2'b00, min_dist_sq});

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE:  if (head_valid && !rsp_valid_ff) state_in = B_DIFF;
         B_DIFF:  state_in = B_SQR;
         B_SQR:   state_in = B_SUM;
         B_SUM:   state_in = B_DEC;
         B_DEC:   state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      pop          = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         B_IDLE:  pop = head_valid && !rsp_valid_ff;
         B_DEC:   rsp_valid_in = keep;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            last_ff[k] <= 32'd0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == B_DEC && keep) begin
            for (int k = 0; k < 3; k++) begin
               last_ff[k] <= pos[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         ent_ff <= head;
      end
      for (int k = 0; k < 3; k++) begin
         mag_ff[k] <= mag_in[k];
         sq_ff[k]  <= mag_ff[k] * mag_ff[k];
      end
      sum_ff <= {2'b00, sq_ff[0]} + {2'b00, sq_ff[1]} + {2'b00, sq_ff[2]};
   end

   // entry holds until the next pop, which waits for the result to drain
   assign rsp_valid = rsp_valid_ff;
   assign rsp_entry = ent_ff;

endmodule
`default_nettype wire

FILE: sv/tlv_path_point_decimator.sv
// Top level of the path point decimator: config registers, parser, queue, distance unit.
// Usage:
//   req_*  : one stream byte per transaction (req_valid / req_stall). Messages are a
//            type byte, a 4-byte big-endian length and the payload.
//   rsp_*  : one decoded point per transaction (rsp_valid / rsp_stall), produced for
//            the first record of a path message and for later records that lie
//            farther than the threshold from the last kept point.
//   csr_*  : register writes; index 0 is the path message type, index 1 the squared
//            distance threshold in mm^2. csr_ready is always high; other indexes
//            are ignored. Write only while the block is idle.
// Throughput: one byte per cycle while req_stall is low. The distance unit steps through
// pop, difference, square, sum and compare for each record, and a kept record's result
// must drain before the next pop; it takes no new record until it is back in idle.
// A kept point goes through the queue and those steps, then waits in the result register.
// A stalled result holds in the output register; records then back up in a
// QUEUE_DEPTH entry queue, and req_stall rises only when that queue is full.
// Reset (synchronous) empties the queue, drops any partial message and restores
// the register defaults (type 1, threshold 250000).
`default_nettype none
module tlv_path_point_decimator #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [7:0]                   req_rx_byte,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic        [31:0]                rsp_t_rel,
   output logic signed [31:0]                rsp_pos_x,
   output logic signed [31:0]                rsp_pos_y,
   output logic signed [31:0]                rsp_pos_z,
   output logic signed [15:0]                rsp_heading_raw,
   output logic signed [15:0]                rsp_speed_raw,
   output logic signed [15:0]                rsp_accel_raw,
   output logic signed [15:0]                rsp_curve_raw,
   output logic        [7:0]                 rsp_point_mode,
   output logic                              rsp_path_start,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [tpd_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [63:0]                  csr_wdata
);
   import tpd_pkg::*;

   logic [7:0]  path_type_ff;
   logic [63:0] min_dist_ff;
   logic        byte_accept;
   logic        push;
   entry_type   push_entry;
   logic        pop;
   entry_type   head;
   logic        head_valid;
   logic        q_full;
   entry_type   rsp_entry;

   assign csr_ready   = 1'b1;
   assign req_stall   = q_full;
   assign byte_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         path_type_ff <= PATH_TYPE_RESET;
         min_dist_ff  <= MIN_DIST_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PATH_TYPE: path_type_ff <= csr_wdata[7:0];
            CSR_MIN_DIST:  min_dist_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   tpd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .byte_accept   (byte_accept),
      .rx_byte       (req_rx_byte),
      .path_msg_type (path_type_ff),
      .push          (push),
      .push_entry    (push_entry)
   );

   tpd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .not_empty  (head_valid),
      .full       (q_full)
   );

   tpd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .head_valid  (head_valid),
      .min_dist_sq (min_dist_ff),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_entry   (rsp_entry)
   );

   assign rsp_t_rel       = rsp_entry.rec.t_rel;
   assign rsp_pos_x       = rsp_entry.rec.pos_x;
   assign rsp_pos_y       = rsp_entry.rec.pos_y;
   assign rsp_pos_z       = rsp_entry.rec.pos_z;
   assign rsp_heading_raw = rsp_entry.rec.heading_raw;
   assign rsp_speed_raw   = rsp_entry.rec.speed_raw;
   assign rsp_accel_raw   = rsp_entry.rec.accel_raw;
   assign rsp_curve_raw   = rsp_entry.rec.curve_raw;
   assign rsp_point_mode  = rsp_entry.rec.point_mode;
   assign rsp_path_start  = rsp_entry.first;

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_full)
      else $error("record pushed into a full queue");

   a_pop_ok: assert property (@(posedge clock) disable iff (reset)
      pop |-> (head_valid && !rsp_valid))
      else $error("record popped while queue empty or result pending");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("result or stall present right after reset");

endmodule
`default_nettype wire
